// ----- design/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Layered pixel compositor package
// Shared constants, the blend coefficient table and the divider interface.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int MAX_LAYERS = 256;
    localparam int CNT_W      = $clog2(MAX_LAYERS + 1);

    localparam logic [31:0] ONE_Q31         = 32'h8000_0000;
    localparam logic [31:0] BLEND_MIN_ALPHA = 32'd12632;

    localparam logic [1:0] MODE_AVG   = 2'd0;
    localparam logic [1:0] MODE_BLEND = 2'd1;
    localparam logic [1:0] MODE_SCORE = 2'd2;

    localparam logic [5:0] BLEND_DIV_STEPS = 6'd32;
    localparam logic [5:0] AVG_DIV_STEPS   = 6'd48;

    typedef logic [31:0] coef_table_t [256];

    // Blend coverage per alpha code: round(a * 2^31 / 255000), zero at 0 and 1, opaque at 255.
    function automatic coef_table_t build_coef_table();
        coef_table_t     tbl;
        longint unsigned num;
        for (int i = 0; i < 256; i++) begin
            num    = longint'(i) * 64'd2147483648 + 64'd127500;
            tbl[i] = 32'(num / 64'd255000);
        end
        tbl[0]   = 32'd0;
        tbl[1]   = 32'd0;
        tbl[255] = ONE_Q31;
        return tbl;
    endfunction

    localparam coef_table_t COEF_TABLE = build_coef_table();

    typedef struct packed {
        logic        start;
        logic [5:0]  steps;
        logic [31:0] den;
        logic [31:0] rem_init;
        logic [63:0] bits;
    } lpc_div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quot;
    } lpc_div_rsp_t;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_ACC  = 10'b00_0000_0010,
        S_NT   = 10'b00_0000_0100,
        S_BDIV = 10'b00_0000_1000,
        S_PP0  = 10'b00_0001_0000,
        S_PP1  = 10'b00_0010_0000,
        S_UPD  = 10'b00_0100_0000,
        S_END  = 10'b00_1000_0000,
        S_ADIV = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

endpackage

// ----- design/lpc_div.sv -----
// ----------------------------------------------------------------------------
// Layered pixel compositor divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpc_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpc_pkg::lpc_div_req_t req,
    output lpc_pkg::lpc_div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [63:0] bits_reg;
    logic [47:0] quot_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_next;

    always_comb begin
        trial    = {rem_reg, bits_reg[63]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[31:0] : trial[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.rem_init;
            den_reg  <= req.den;
            bits_reg <= req.bits;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[62:0], 1'b0};
            quot_reg <= {quot_reg[46:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ----- design/layered_pixel_compositor.sv -----
// ----------------------------------------------------------------------------
// Layered pixel compositor
// Folds a run of layer samples into one pixel by mean, blend or best score.
// ----------------------------------------------------------------------------
// One layer is taken at a time. An uncovered layer or one with alpha of 0 or 1
// goes through S_ACC and S_END; a blended layer adds S_NT, a divider run of
// BLEND_DIV_STEPS steps that forms the blend weight, two partial products and
// S_UPD. The last layer of a run adds S_OUT, after an AVG_DIV_STEPS run of the
// same divider for the mean in average mode with a nonzero weight sum. The result
// waits in an output register, so the next run may start before it is taken.
module layered_pixel_compositor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,     // blend_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // layer_value[31:0], layer_alpha[39:32],
                                       // layer_score[55:40]
    input  logic        s_tuser,       // layer_covered
    input  logic        s_tlast,       // last_layer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // pixel_value
    output logic        m_tuser        // pixel_valid
);

    localparam logic signed [48:0] WS_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] WS_MIN = -49'sh0_8000_0000_0000;

    lpc_pkg::state_t state_reg, state_next;

    logic [1:0]                  mode_reg;
    logic [lpc_pkg::CNT_W-1:0]   cnt_reg;
    logic signed [47:0]          ws_reg;
    logic [15:0]                 as_reg;
    logic signed [31:0]          bv_reg;
    logic [31:0]                 ba_reg;
    logic [15:0]                 bs_reg;
    logic signed [31:0]          bval_reg;
    logic                        anycov_reg;

    logic signed [31:0] h_reg;
    logic [7:0]         a_reg;
    logic [15:0]        sc_reg;
    logic               cov_reg;
    logic               last_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        c_reg;
    logic [31:0]        nt_reg;
    logic [31:0]        w_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic [63:0]        acc_reg;
    logic signed [31:0] avg_res_reg;

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_user_reg;

    lpc_pkg::lpc_div_req_t div_req;
    lpc_pkg::lpc_div_rsp_t div_rsp;

    logic               active;
    logic               do_blend;
    logic [7:0]         wgt;
    logic signed [40:0] avg_prod;
    logic signed [48:0] ws_sum;
    logic signed [47:0] ws_next;
    logic [16:0]        as_sum;
    logic [15:0]        as_next;
    logic [31:0]        c_w;
    logic [63:0]        prod_next;
    logic [31:0]        nt_w;
    logic [31:0]        num_low;
    logic signed [32:0] d33;
    logic [47:0]        ws_mag;
    logic [47:0]        avg_num;
    logic [47:0]        quot_w;
    logic signed [31:0] avg_res_next;
    logic [32:0]        r_w;
    logic signed [33:0] v34;
    logic               res_valid;
    logic signed [31:0] res_value;
    logic               load_out;

    lpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        active    = cov_reg && (cnt_reg < lpc_pkg::CNT_W'(lpc_pkg::MAX_LAYERS));
        do_blend  = active && (a_reg > 8'd1);
        wgt       = (a_reg > 8'd1) ? a_reg : 8'd0;
        avg_prod  = h_reg * $signed({1'b0, wgt});
        ws_sum    = 49'(ws_reg) + 49'(avg_prod);
        if (ws_sum > WS_MAX) begin
            ws_next = WS_MAX[47:0];
        end else if (ws_sum < WS_MIN) begin
            ws_next = WS_MIN[47:0];
        end else begin
            ws_next = ws_sum[47:0];
        end
        as_sum  = {1'b0, as_reg} + {9'd0, wgt};
        as_next = as_sum[16] ? 16'hFFFF : as_sum[15:0];

        c_w       = lpc_pkg::COEF_TABLE[a_reg];
        prod_next = ba_reg * (lpc_pkg::ONE_Q31 - c_w);

        nt_w    = 32'((prod_reg + 64'h4000_0000) >> 31) + c_reg;
        // Low word of c * 2^31 + nt / 2; the sum never carries past bit 31.
        num_low = {c_reg[0], 31'd0} + {1'b0, nt_w[31:1]};
        d33     = 33'(h_reg) - 33'(bv_reg);

        ws_mag  = ws_reg[47] ? 48'(-ws_reg) : 48'(ws_reg);
        avg_num = ws_mag + {33'd0, as_reg[15:1]};

        div_req = '0;
        if (state_reg == lpc_pkg::S_NT) begin
            div_req.start    = 1'b1;
            div_req.steps    = lpc_pkg::BLEND_DIV_STEPS;
            div_req.den      = nt_w;
            div_req.rem_init = {1'b0, c_reg[31:1]};
            div_req.bits     = {num_low, 32'd0};
        end else if (state_reg == lpc_pkg::S_END && last_reg
                     && mode_reg == lpc_pkg::MODE_AVG && as_reg != 16'd0) begin
            div_req.start    = 1'b1;
            div_req.steps    = lpc_pkg::AVG_DIV_STEPS;
            div_req.den      = {16'd0, as_reg};
            div_req.rem_init = 32'd0;
            div_req.bits     = {avg_num, 16'd0};
        end

        quot_w = div_rsp.quot;
        if (ws_reg[47]) begin
            avg_res_next = (quot_w > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                         : -$signed(quot_w[31:0]);
        end else begin
            avg_res_next = (quot_w > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                         : $signed(quot_w[31:0]);
        end

        r_w = 33'((acc_reg + 64'h4000_0000) >> 31);
        v34 = neg_reg ? 34'(bv_reg) - 34'(r_w) : 34'(bv_reg) + 34'(r_w);

        case (mode_reg)
            lpc_pkg::MODE_AVG: begin
                res_valid = (as_reg != 16'd0);
                res_value = avg_res_reg;
            end
            lpc_pkg::MODE_BLEND: begin
                res_valid = (ba_reg > lpc_pkg::BLEND_MIN_ALPHA);
                res_value = bv_reg;
            end
            lpc_pkg::MODE_SCORE: begin
                res_valid = anycov_reg && (bval_reg > 32'sd0);
                res_value = bval_reg;
            end
            default: begin
                res_valid = 1'b0;
                res_value = 32'sd0;
            end
        endcase
        if (!res_valid) begin
            res_value = 32'sd0;
        end

        load_out = (state_reg == lpc_pkg::S_OUT) && (!out_valid_reg || m_tready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpc_pkg::S_IDLE: if (s_tvalid) state_next = lpc_pkg::S_ACC;
            lpc_pkg::S_ACC:  state_next = do_blend ? lpc_pkg::S_NT : lpc_pkg::S_END;
            lpc_pkg::S_NT:   state_next = lpc_pkg::S_BDIV;
            lpc_pkg::S_BDIV: if (div_rsp.done) state_next = lpc_pkg::S_PP0;
            lpc_pkg::S_PP0:  state_next = lpc_pkg::S_PP1;
            lpc_pkg::S_PP1:  state_next = lpc_pkg::S_UPD;
            lpc_pkg::S_UPD:  state_next = lpc_pkg::S_END;
            lpc_pkg::S_END: begin
                if (!last_reg) begin
                    state_next = lpc_pkg::S_IDLE;
                end else if (div_req.start) begin
                    state_next = lpc_pkg::S_ADIV;
                end else begin
                    state_next = lpc_pkg::S_OUT;
                end
            end
            lpc_pkg::S_ADIV: if (div_rsp.done) state_next = lpc_pkg::S_OUT;
            lpc_pkg::S_OUT:  if (load_out) state_next = lpc_pkg::S_IDLE;
            default:         state_next = lpc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lpc_pkg::S_IDLE;
            mode_reg      <= lpc_pkg::MODE_AVG;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ws_reg        <= '0;
            as_reg        <= '0;
            bv_reg        <= '0;
            ba_reg        <= '0;
            bs_reg        <= '0;
            bval_reg      <= '0;
            anycov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == lpc_pkg::S_ACC && active) begin
                cnt_reg    <= cnt_reg + lpc_pkg::CNT_W'(1);
                ws_reg     <= ws_next;
                as_reg     <= as_next;
                anycov_reg <= 1'b1;
                if (sc_reg > bs_reg) begin
                    bs_reg   <= sc_reg;
                    bval_reg <= h_reg;
                end
            end
            if (state_reg == lpc_pkg::S_UPD) begin
                bv_reg <= v34[31:0];
                ba_reg <= nt_reg;
            end
            if (load_out) begin
                // Loading the pixel into the output register ends the run: all run state clears.
                out_valid_reg <= 1'b1;
                cnt_reg       <= '0;
                ws_reg        <= '0;
                as_reg        <= '0;
                bv_reg        <= '0;
                ba_reg        <= '0;
                bs_reg        <= '0;
                bval_reg      <= '0;
                anycov_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lpc_pkg::S_IDLE) begin
            h_reg    <= $signed(s_tdata[31:0]);
            a_reg    <= s_tdata[39:32];
            sc_reg   <= s_tdata[55:40];
            cov_reg  <= s_tuser;
            last_reg <= s_tlast;
        end
        if (state_reg == lpc_pkg::S_ACC) begin
            prod_reg <= prod_next;
            c_reg    <= c_w;
        end
        if (state_reg == lpc_pkg::S_NT) begin
            nt_reg  <= nt_w;
            neg_reg <= d33[32];
            mag_reg <= d33[32] ? 33'(-d33) : 33'(d33);
        end
        if (state_reg == lpc_pkg::S_BDIV && div_rsp.done) begin
            w_reg <= div_rsp.quot[31:0];
        end
        if (state_reg == lpc_pkg::S_PP0) begin
            acc_reg <= 64'({16'd0, mag_reg} * {33'd0, w_reg[15:0]});
        end
        if (state_reg == lpc_pkg::S_PP1) begin
            acc_reg <= acc_reg + (64'({16'd0, mag_reg} * {33'd0, w_reg[31:16]}) << 16);
        end
        if (state_reg == lpc_pkg::S_ADIV && div_rsp.done) begin
            avg_res_reg <= avg_res_next;
        end
        if (load_out) begin
            out_data_reg <= res_value;
            out_user_reg <= res_valid;
        end
    end

    assign s_tready = (state_reg == lpc_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- design/lpc_checker.sv -----
// ----------------------------------------------------------------------------
// Layered pixel compositor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module lpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result transfer keeps its valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // An invalid pixel always carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("invalid pixel with nonzero value");

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result offered right after reset");

    // The input is not ready in the cycle after an accepted layer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

endmodule

bind layered_pixel_compositor lpc_checker u_lpc_checker (.*);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Layered pixel compositor testbench
// Drives runs of layer samples in every blend mode, predicts each composited
// pixel, or takes it from the directed table, and checks every output transfer against it.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  N_RANDOM   = 1050;
    localparam int  IDLE_PCT   = 36;
    localparam int  HOLD_LEN   = 400;
    localparam int  SETTLE     = 80;
    localparam int  WDOG_LIMIT = 40000;
    localparam logic [1:0] MODE_AVG   = lpc_pkg::MODE_AVG;
    localparam logic [1:0] MODE_BLEND = lpc_pkg::MODE_BLEND;
    localparam logic [1:0] MODE_SCORE = lpc_pkg::MODE_SCORE;
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] value;
        logic [7:0]  alpha;
        logic [15:0] score;
        logic        covered;
        logic        last;
        logic        typed;
        logic [31:0] exp_value;
        logic        exp_valid;
    } dir_row_t;

    typedef struct {
        logic [31:0] value;
        logic        valid;
    } pixel_t;

    localparam int N_DIR = 19;
    dir_row_t dir_rows [N_DIR] = '{
        '{MODE_AVG,   32'h0064_0000, 8'd255, 16'h0000, 1'b1, 1'b1, 1'b1, 32'h0064_0000, 1'b1},
        '{MODE_AVG,   32'h1234_0000, 8'd1,   16'h0000, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0},
        '{MODE_AVG,   32'h0000_0005, 8'd200, 16'h0000, 1'b0, 1'b1, 1'b1, 32'h0, 1'b0},
        '{MODE_AVG,   32'h7fff_ffff, 8'd255, 16'hffff, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{MODE_AVG,   32'h8000_0000, 8'd255, 16'h0000, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
        '{MODE_AVG,   32'h0003_0000, 8'd0,   16'h0007, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{MODE_AVG,   32'h0001_0000, 8'd128, 16'h0000, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
        '{MODE_BLEND, 32'h0001_0000, 8'd255, 16'h0000, 1'b1, 1'b1, 1'b1, 32'h0001_0000, 1'b1},
        '{MODE_BLEND, 32'h0005_0000, 8'd2,   16'h0000, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
        '{MODE_BLEND, 32'hfffe_0000, 8'd100, 16'h0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{MODE_BLEND, 32'h7fff_ffff, 8'd254, 16'h0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{MODE_BLEND, 32'h0004_0000, 8'd1,   16'h0000, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
        '{MODE_SCORE, 32'h0000_0005, 8'd0,   16'hffff, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{MODE_SCORE, 32'h0000_0009, 8'd255, 16'h000a, 1'b1, 1'b1, 1'b1, 32'h5, 1'b1},
        '{MODE_SCORE, 32'hffff_0000, 8'd10,  16'h0014, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0},
        '{MODE_SCORE, 32'h0000_0003, 8'd10,  16'h0000, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0},
        '{MODE_SCORE, 32'h0000_0007, 8'd10,  16'h0032, 1'b0, 1'b1, 1'b1, 32'h0, 1'b0},
        '{MODE_UNDEF, 32'h0001_0000, 8'd255, 16'h0005, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0},
        '{MODE_AVG,   32'h0001_0000, 8'd0,   16'h0000, 1'b0, 1'b1, 1'b1, 32'h0, 1'b0}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // Shadow of the compositor state.
    logic [1:0]      sh_mode;
    longint          sh_wsum;
    int unsigned     sh_asum;
    longint          sh_bval;
    longint unsigned sh_balpha;
    int unsigned     sh_bscore;
    longint          sh_best;
    bit              sh_anycov;
    int unsigned     sh_count;

    pixel_t pixel_q[$];
    bit     next_typed;
    pixel_t next_typed_pix;

    int     n_errors;
    int     idle_cycles;
    int     sent;
    bit     calm;
    bit     hold_req;
    bit     hold_taken;
    int     hold_cnt;
    logic [1:0] cur_mode;

    layered_pixel_compositor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void clear_shadow();
        sh_wsum   = 0;
        sh_asum   = 0;
        sh_bval   = 0;
        sh_balpha = 0;
        sh_bscore = 0;
        sh_best   = 0;
        sh_anycov = 0;
        sh_count  = 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Folds one covered layer into the blend accumulators.
    function automatic void blend_fold(input longint h, input int unsigned a);
        longint unsigned c, prod, nt, w, mag, r;
        longint d;
        if (a <= 1) return;
        if (a == 255) c = 64'd2147483648;
        else c = (longint'(a) * 64'd2147483648 + 64'd127500) / 64'd255000;
        prod = sh_balpha * (64'd2147483648 - c);
        nt   = ((prod + (64'd1 << 30)) >> 31) + c;
        w    = (c * 64'd2147483648 + nt / 2) / nt;
        d    = h - sh_bval;
        mag  = (d < 0) ? longint'(-d) : longint'(d);
        r    = (mag * w + (64'd1 << 30)) >> 31;
        sh_bval   = (d < 0) ? sh_bval - longint'(r) : sh_bval + longint'(r);
        sh_bval   = longint'($signed(sh_bval[31:0]));
        sh_balpha = nt;
    endfunction

    // Updates the shadow for one accepted layer; returns 1 if a pixel results.
    function automatic bit composite_layer(input logic [31:0] value, input logic [7:0] alpha,
                                           input logic [15:0] score, input logic covered,
                                           input logic last, output pixel_t pix);
        longint          h;
        int unsigned     wgt;
        longint          s;
        longint unsigned mag, q;
        longint          v;
        bit              ok;
        h   = longint'($signed(value));
        pix = '{32'h0, 1'b0};
        if (covered && sh_count < lpc_pkg::MAX_LAYERS) begin
            sh_count++;
            wgt = (alpha <= 1) ? 0 : alpha;
            s   = sh_wsum + h * longint'(wgt);
            if (s > 64'sd140737488355327) s = 64'sd140737488355327;
            if (s < -64'sd140737488355328) s = -64'sd140737488355328;
            sh_wsum = s;
            sh_asum = (sh_asum + wgt > 65535) ? 65535 : sh_asum + wgt;
            blend_fold(h, alpha);
            sh_anycov = 1;
            if (score > sh_bscore) begin
                sh_bscore = score;
                sh_best   = h;
            end
        end
        if (!last) return 0;
        ok = 0;
        v  = 0;
        case (sh_mode)
            MODE_AVG: begin
                if (sh_asum != 0) begin
                    mag = (sh_wsum < 0) ? longint'(-sh_wsum) : longint'(sh_wsum);
                    q   = (mag + sh_asum / 2) / sh_asum;
                    if (q > 64'd4294967296) q = 64'd4294967296;
                    v = (sh_wsum < 0) ? -longint'(q) : longint'(q);
                    if (v > 64'sd2147483647) v = 64'sd2147483647;
                    if (v < -64'sd2147483648) v = -64'sd2147483648;
                    ok = 1;
                end
            end
            MODE_BLEND: begin
                ok = sh_balpha > lpc_pkg::BLEND_MIN_ALPHA;
                v  = sh_bval;
            end
            MODE_SCORE: begin
                ok = sh_anycov && sh_best > 0;
                v  = sh_best;
            end
            default: ok = 0;
        endcase
        pix.valid = ok;
        pix.value = ok ? v[31:0] : 32'h0;
        clear_shadow();
        return 1;
    endfunction

    // Input and output monitors, configuration shadow and watchdog.
    always @(posedge aclk) begin
        pixel_t pix;
        pixel_t want;
        if (!aresetn) begin
            sh_mode = MODE_AVG;
            clear_shadow();
        end else begin
            idle_cycles++;
            if (cfg_we) begin
                sh_mode = cfg_wdata;
                idle_cycles = 0;
            end
            if (s_tvalid && s_tready) begin
                idle_cycles = 0;
                if (composite_layer(s_tdata[31:0], s_tdata[39:32], s_tdata[55:40],
                                    s_tuser, s_tlast, pix)) begin
                    if (next_typed) pix = next_typed_pix;
                    pixel_q = {pixel_q, pix};
                end
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected pixel", m_tdata, 32'h0);
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("pixel_value", m_tdata, want.value);
                    if (m_tuser !== want.valid)
                        report_mismatch("pixel_valid", {31'h0, m_tuser}, {31'h0, want.valid});
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog expired at %0t", $realtime);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Result side: random stalls, a calm stretch and one long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1;
            hold_cnt = HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_layer(input logic [31:0] value, input logic [7:0] alpha,
                              input logic [15:0] score, input logic covered,
                              input logic last);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {score, alpha, value};
        s_tuser  <= covered;
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
        sent++;
    endtask

    // Mode changes only once the block has gone quiet.
    task automatic set_mode(input logic [1:0] mode);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_mode = mode;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0040_0000);
            3: return -$urandom_range(32'h0040_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_alpha();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            3: return 8'd254;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        logic [1:0] mode;
        int         run_len;
        int         since_cfg;
        bit         long_done;
        n_errors    = 0;
        idle_cycles = 0;
        sent        = 0;
        calm        = 0;
        hold_req    = 0;
        hold_taken  = 0;
        hold_cnt    = 0;
        next_typed  = 0;
        cur_mode    = MODE_AVG;
        long_done   = 0;
        since_cfg   = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 2'd0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_mode(MODE_AVG);
        for (int i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].mode != cur_mode) set_mode(dir_rows[i].mode);
            next_typed     = dir_rows[i].typed;
            next_typed_pix = '{dir_rows[i].exp_value, dir_rows[i].exp_valid};
            send_layer(dir_rows[i].value, dir_rows[i].alpha, dir_rows[i].score,
                       dir_rows[i].covered, dir_rows[i].last);
        end
        next_typed = 0;
        set_mode(MODE_SCORE);

        sent = 0;
        while (sent < N_RANDOM) begin
            calm = (sent >= 300 && sent < 500);
            if (sent >= 700) hold_req = 1;
            if (since_cfg >= 100) begin
                case ($urandom_range(4))
                    0: mode = MODE_AVG;
                    1: mode = MODE_UNDEF;
                    default: mode = 2'($urandom_range(2));
                endcase
                set_mode(mode);
                since_cfg = 0;
            end
            // One run longer than the layer limit, the rest mostly short.
            if (!long_done && sent >= 550) begin
                run_len = lpc_pkg::MAX_LAYERS + 20;
                long_done = 1;
            end else if ($urandom_range(9) == 0) begin
                run_len = $urandom_range(24, 9);
            end else begin
                run_len = $urandom_range(6, 1);
            end
            for (int k = 0; k < run_len; k++) begin
                send_layer(rand_value(), rand_alpha(),
                           ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom),
                           $urandom_range(99) < 85, k == run_len - 1);
                since_cfg++;
            end
        end
        s_tvalid <= 1'b0;
        calm = 0;

        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
